@@ rtl/core/b2da_pkg.sv @@
// Package for the binary to decimal ASCII converter.
// Holds the shared widths, the decimal digit constants and the
// command/status structs between controller and datapath. No dependencies.
package b2da_pkg;

  localparam int VALUE_W        = 64;
  localparam int DEF_VALUE_BITS = 64;
  localparam int DIGITS         = 20;
  localparam int DIGIT_W        = 4;
  localparam int BCD_W          = DIGITS * DIGIT_W;
  localparam int CHAR_W         = 6;
  localparam int IDX_W          = 5;

  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;
  localparam logic [1:0]         ASCII_ZERO_HI = 2'b11;

  typedef struct packed {
    logic load;
    logic conv;
    logic skip;
    logic emit;
  } b2da_cmd_t;

  typedef struct packed {
    logic bits_done;
    logic top_zero;
    logic one_left;
  } b2da_sts_t;

endpackage

@@ rtl/core/binary_to_decimal_ascii.sv @@
// Binary to decimal ASCII converter, top level.
// Instantiates b2da_ctrl and b2da_datapath. Depends on b2da_pkg.
//
// A request is taken when start is high and busy is low. The low VALUE_BITS
// bits of in_value are converted by double dabble, one bit per cycle. Leading
// zero digits are then dropped at one digit per cycle (up to 19 of them), and
// the skip state then finds the first digit to emit. After that one digit is
// emitted per cycle, most significant first (1 to 20 digits). Each digit
// appears for one cycle with out_valid high, in the cycle after it is emitted;
// out_last_digit marks the final one, which is strobed in the first cycle that
// busy is low again. The receiver cannot stall the output, so it must take
// every strobed digit. Dropped and emitted digits always total 20, so the time
// a request occupies from start to the return of busy low is the same
// whatever the value.
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic [IDX_W-1:0]   out_digit_index,
  output logic               out_last_digit
);

  b2da_cmd_t cmd;
  b2da_sts_t sts;

  b2da_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  b2da_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_digit_char  (out_digit_char),
    .out_digit_index (out_digit_index),
    .out_last_digit  (out_last_digit)
  );

endmodule

@@ rtl/core/b2da_ctrl.sv @@
// Controller of the binary to decimal ASCII converter.
// Sequences load, double-dabble conversion, leading-zero skip and emission.
// Depends on b2da_pkg.
module b2da_ctrl
  import b2da_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  b2da_sts_t sts_i,
  output b2da_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.bits_done) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (sts_i.top_zero && !sts_i.one_left) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.one_left) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/core/b2da_datapath.sv @@
// Datapath of the binary to decimal ASCII converter.
// Holds the binary shift register, the BCD digit register, the counters
// and the output registers. Depends on b2da_pkg.
module b2da_datapath
  import b2da_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  b2da_cmd_t         cmd_i,
  output b2da_sts_t         sts_o,
  input  logic [VALUE_W-1:0] in_value,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_digit_char,
  output logic [IDX_W-1:0]  out_digit_index,
  output logic              out_last_digit
);

  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(VALUE_BITS - 1);
  localparam logic [IDX_W-1:0] DIG_ALL  = IDX_W'(DIGITS);

  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]      dig_left_r, dig_left_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic [IDX_W-1:0]      out_index_r;
  logic                  out_last_r;
  logic [DIGIT_W-1:0]    top_digit;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

  assign sts_o.bits_done = (bit_cnt_r == BIT_LAST);
  assign sts_o.top_zero  = (top_digit == '0);
  assign sts_o.one_left  = (dig_left_r == IDX_W'(1));

  always_comb begin
    bin_nxt      = bin_r;
    bcd_nxt      = bcd_r;
    bit_cnt_nxt  = bit_cnt_r;
    dig_left_nxt = dig_left_r;
    idx_nxt      = idx_r;
    if (cmd_i.load) begin
      bin_nxt      = in_value[VALUE_BITS-1:0];
      bcd_nxt      = '0;
      bit_cnt_nxt  = '0;
      dig_left_nxt = DIG_ALL;
      idx_nxt      = '0;
    end else if (cmd_i.conv) begin
      bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
      bin_nxt     = {bin_r[VALUE_BITS-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + CNT_W'(1);
    end else if (cmd_i.skip || cmd_i.emit) begin
      bcd_nxt      = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      dig_left_nxt = dig_left_r - IDX_W'(1);
      if (cmd_i.emit) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_left_r <= dig_left_nxt;
    idx_r      <= idx_nxt;
    if (cmd_i.emit) begin
      out_char_r  <= {ASCII_ZERO_HI, top_digit};
      out_index_r <= idx_r;
      out_last_r  <= sts_o.one_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.emit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digit_char  = out_char_r;
  assign out_digit_index = out_index_r;
  assign out_last_digit  = out_last_r;

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= CHAR_W'(48)) && (out_digit_char <= CHAR_W'(57)))
    else $error("digit character out of range");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_digit |=>
      out_valid && (out_digit_index == $past(out_digit_index) + IDX_W'(1)))
    else $error("digit run broken or index not advancing");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_digit |=> !out_valid)
    else $error("request strobe after last digit");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load |=> (idx_r == '0) && (dig_left_r == DIG_ALL) && (bit_cnt_r == '0))
    else $error("load did not initialize counters");

endmodule
